// ===== rtl/range_priority_motion_arbiter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Range priority motion arbiter assertion macros
// Shared property forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef RANGE_PRIORITY_MOTION_ARBITER_UNIT_MACROS_SVH
`define RANGE_PRIORITY_MOTION_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define RPMA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define RPMA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/rpma_pkg.sv =====
// ----------------------------------------------------------------------------
// rpma_pkg
// Types, constants and register codes shared by the motion arbiter RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package rpma_pkg;

  // Field widths.
  localparam int unsigned RANGE_W     = 16;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned VEL_W       = 12;
  localparam int unsigned RULE_W      = 4;
  localparam int unsigned NUM_SENSORS = 12;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  // Ratio thresholds are Q4.12, so the front-right reading is scaled by 2^12.
  localparam int unsigned RATIO_FRAC  = 12;
  localparam int unsigned PROD_W      = 2 * RANGE_W;
  localparam int unsigned SHIFTED_W   = RANGE_W + RATIO_FRAC;

  // Diagonal push is 0.70711 in Q0.16, rounded half up.
  localparam int unsigned DIAG_FRAC   = 16;
  localparam int unsigned DIAG_PROD_W = VEL_W + DIAG_FRAC;
  localparam logic [DIAG_FRAC-1:0] DIAG_SCALE = 16'd46341;
  localparam logic [DIAG_FRAC-1:0] DIAG_ROUND = 16'd32768;

  // Sensor positions in the range vector.
  localparam int unsigned SNS_RIGHT       = 0;
  localparam int unsigned SNS_FRONT_RIGHT = 1;
  localparam int unsigned SNS_FRONT       = 2;
  localparam int unsigned SNS_FRONT_LEFT  = 3;
  localparam int unsigned SNS_LEFT        = 4;
  localparam int unsigned SNS_DOWN_FRONT  = 5;
  localparam int unsigned SNS_DOWN        = 6;
  localparam int unsigned SNS_DOWN_BACK   = 7;
  localparam int unsigned SNS_BACK_LOW    = 8;
  localparam int unsigned SNS_UP_BACK     = 9;
  localparam int unsigned SNS_UP          = 10;
  localparam int unsigned SNS_UP_FRONT    = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_DISTANCE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_SPEED        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALTITUDE_TOLERANCE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_TOLERANCE      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_VISIBLE_DISTANCE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATIO            = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_LEFT_RATIO     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_RIGHT_RATIO    = 4'd7;

  // Configuration reset values.
  localparam logic [RANGE_W-1:0] OBSTACLE_DISTANCE_RST     = 16'd1000;
  localparam logic [VEL_W-1:0]   OBSTACLE_SPEED_RST        = 12'd500;
  localparam logic [RANGE_W-1:0] ALTITUDE_TOLERANCE_RST    = 16'd300;
  localparam logic [RANGE_W-1:0] MIDDLE_TOLERANCE_RST      = 16'd300;
  localparam logic [RANGE_W-1:0] WALL_VISIBLE_DISTANCE_RST = 16'd10000;
  localparam logic [RANGE_W-1:0] TURN_RATIO_RST            = 16'd5793;
  localparam logic [RANGE_W-1:0] ADJUST_LEFT_RATIO_RST     = 16'd5213;
  localparam logic [RANGE_W-1:0] ADJUST_RIGHT_RATIO_RST    = 16'd6372;

  // Default command speeds.
  localparam int unsigned ALTITUDE_SPEED_DEF = 300;
  localparam int unsigned CRUISE_SPEED_DEF   = 500;
  localparam int unsigned TURN_RATE_DEF      = 500;
  localparam int unsigned CENTER_SPEED_DEF   = 300;
  localparam int unsigned SEEK_SPEED_DEF     = 300;

  // Rule numbers in priority order.
  typedef enum logic [RULE_W-1:0] {
    RULE_OBSTACLE     = 4'd0,
    RULE_ALTITUDE     = 4'd1,
    RULE_TURN_RIGHT   = 4'd2,
    RULE_TURN_LEFT    = 4'd3,
    RULE_ADJUST_LEFT  = 4'd4,
    RULE_ADJUST_RIGHT = 4'd5,
    RULE_MIDDLE       = 4'd6,
    RULE_STRAIGHT     = 4'd7,
    RULE_FIND         = 4'd8
  } rule_e;

  typedef logic [RANGE_W-1:0] range_t;

  // Register file contents.
  typedef struct packed {
    logic [RANGE_W-1:0] obstacle_distance;
    logic [VEL_W-1:0]   obstacle_speed;
    logic [RANGE_W-1:0] altitude_tolerance;
    logic [RANGE_W-1:0] middle_tolerance;
    logic [RANGE_W-1:0] wall_visible_distance;
    logic [RANGE_W-1:0] turn_ratio;
    logic [RANGE_W-1:0] adjust_left_ratio;
    logic [RANGE_W-1:0] adjust_right_ratio;
  } cfg_t;

  // Sense stage to arbitration stage.
  typedef struct packed {
    logic [NUM_SENSORS-1:0] close;
    logic                   alt_fire;
    logic                   dn_lt_up;
    logic                   r_gt_f;
    logic                   f_gt_r;
    logic                   l_le_f;
    logic                   r_lt_l;
    logic                   mid_out;
    logic                   wall;
    logic [RANGE_W-1:0]     front_right;
    logic [PROD_W-1:0]      prod_turn;
    logic [PROD_W-1:0]      prod_adj_left;
    logic [PROD_W-1:0]      prod_adj_right;
    logic [VEL_W-1:0]       vel;
    logic [VEL_W-1:0]       diag;
  } sense_t;

  // Arbitration stage to command stage. Push coefficients are two's complement.
  typedef struct packed {
    rule_e            rule;
    logic             dn_lt_up;
    logic             f_gt_r;
    logic             r_lt_l;
    logic [1:0]       x_str;
    logic [3:0]       x_diag;
    logic [1:0]       y_str;
    logic [3:0]       y_diag;
    logic [1:0]       z_str;
    logic [3:0]       z_diag;
    logic [VEL_W-1:0] vel;
    logic [VEL_W-1:0] diag;
  } arb_t;

  // Final command.
  typedef struct packed {
    logic [SPEED_W-1:0] speed_x;
    logic [SPEED_W-1:0] speed_y;
    logic [SPEED_W-1:0] speed_z;
    logic [SPEED_W-1:0] yaw_rate;
    rule_e              rule;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/rpma_if.sv =====
// ----------------------------------------------------------------------------
// rpma_if
// Valid/ready channels for the range set beat and the command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpma_in_if import rpma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] right_range;
  logic [RANGE_W-1:0] front_right_range;
  logic [RANGE_W-1:0] front_range;
  logic [RANGE_W-1:0] front_left_range;
  logic [RANGE_W-1:0] left_range;
  logic [RANGE_W-1:0] down_front_range;
  logic [RANGE_W-1:0] down_range;
  logic [RANGE_W-1:0] down_back_range;
  logic [RANGE_W-1:0] back_low_range;
  logic [RANGE_W-1:0] up_back_range;
  logic [RANGE_W-1:0] up_range;
  logic [RANGE_W-1:0] up_front_range;

  modport source (
    output valid, right_range, front_right_range, front_range, front_left_range,
           left_range, down_front_range, down_range, down_back_range,
           back_low_range, up_back_range, up_range, up_front_range,
    input  ready
  );

  modport sink (
    input  valid, right_range, front_right_range, front_range, front_left_range,
           left_range, down_front_range, down_range, down_back_range,
           back_low_range, up_back_range, up_range, up_front_range,
    output ready
  );
endinterface

interface rpma_out_if import rpma_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_x;
  logic signed [SPEED_W-1:0] speed_y;
  logic signed [SPEED_W-1:0] speed_z;
  logic signed [SPEED_W-1:0] yaw_rate;
  logic [RULE_W-1:0]         rule_fired;

  modport source (
    output valid, speed_x, speed_y, speed_z, yaw_rate, rule_fired,
    input  ready
  );

  modport sink (
    input  valid, speed_x, speed_y, speed_z, yaw_rate, rule_fired,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/range_priority_motion_arbiter_unit.sv =====
// ----------------------------------------------------------------------------
// range_priority_motion_arbiter_unit
// Turns twelve range readings into one prioritized velocity command.
// ----------------------------------------------------------------------------
// Each range set beat yields exactly one command beat, and a new beat can be
// accepted on every clock unless a stalled output has backed up every stage:
// the unit is a three-stage pipeline (compare and multiply, rule priority,
// command build), and each stage register has its own valid bit and takes a
// beat whenever it is empty or draining, so bubbles close up and a stalled
// output holds its beat while the stages behind it keep filling. The eight
// configuration registers are written through the plain write port and
// should only change while no beat is in flight.
`default_nettype none
`include "range_priority_motion_arbiter_unit_macros.svh"

module range_priority_motion_arbiter_unit import rpma_pkg::*; #(
  parameter int unsigned ALTITUDE_SPEED = ALTITUDE_SPEED_DEF,
  parameter int unsigned CRUISE_SPEED   = CRUISE_SPEED_DEF,
  parameter int unsigned TURN_RATE      = TURN_RATE_DEF,
  parameter int unsigned CENTER_SPEED   = CENTER_SPEED_DEF,
  parameter int unsigned SEEK_SPEED     = SEEK_SPEED_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  rpma_in_if.sink                    in_i,
  rpma_out_if.source                 out_o
);

  localparam logic signed [SPEED_W-1:0] SeekNeg = -$signed(SPEED_W'(SEEK_SPEED));

  cfg_t                     cfg_q;
  range_t [NUM_SENSORS-1:0] ranges;
  logic                     s1_valid, s1_ready;
  sense_t                   s1_data;
  logic                     s2_valid, s2_ready;
  arb_t                     s2_data;
  logic                     s3_ready;
  cmd_t                     s3_data;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obstacle_distance     <= OBSTACLE_DISTANCE_RST;
      cfg_q.obstacle_speed        <= OBSTACLE_SPEED_RST;
      cfg_q.altitude_tolerance    <= ALTITUDE_TOLERANCE_RST;
      cfg_q.middle_tolerance      <= MIDDLE_TOLERANCE_RST;
      cfg_q.wall_visible_distance <= WALL_VISIBLE_DISTANCE_RST;
      cfg_q.turn_ratio            <= TURN_RATIO_RST;
      cfg_q.adjust_left_ratio     <= ADJUST_LEFT_RATIO_RST;
      cfg_q.adjust_right_ratio    <= ADJUST_RIGHT_RATIO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OBSTACLE_DISTANCE:     cfg_q.obstacle_distance     <= cfg_data_i;
        CFG_OBSTACLE_SPEED:        cfg_q.obstacle_speed        <= cfg_data_i[VEL_W-1:0];
        CFG_ALTITUDE_TOLERANCE:    cfg_q.altitude_tolerance    <= cfg_data_i;
        CFG_MIDDLE_TOLERANCE:      cfg_q.middle_tolerance      <= cfg_data_i;
        CFG_WALL_VISIBLE_DISTANCE: cfg_q.wall_visible_distance <= cfg_data_i;
        CFG_TURN_RATIO:            cfg_q.turn_ratio            <= cfg_data_i;
        CFG_ADJUST_LEFT_RATIO:     cfg_q.adjust_left_ratio     <= cfg_data_i;
        CFG_ADJUST_RIGHT_RATIO:    cfg_q.adjust_right_ratio    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Gather the readings in sensor order.
  assign ranges[SNS_RIGHT]       = in_i.right_range;
  assign ranges[SNS_FRONT_RIGHT] = in_i.front_right_range;
  assign ranges[SNS_FRONT]       = in_i.front_range;
  assign ranges[SNS_FRONT_LEFT]  = in_i.front_left_range;
  assign ranges[SNS_LEFT]        = in_i.left_range;
  assign ranges[SNS_DOWN_FRONT]  = in_i.down_front_range;
  assign ranges[SNS_DOWN]        = in_i.down_range;
  assign ranges[SNS_DOWN_BACK]   = in_i.down_back_range;
  assign ranges[SNS_BACK_LOW]    = in_i.back_low_range;
  assign ranges[SNS_UP_BACK]     = in_i.up_back_range;
  assign ranges[SNS_UP]          = in_i.up_range;
  assign ranges[SNS_UP_FRONT]    = in_i.up_front_range;

  // Stage one: comparisons and products.
  rpma_sense u_sense (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .ranges_i (ranges),
    .cfg_i    (cfg_q),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .data_o   (s1_data)
  );

  // Stage two: rule priority.
  rpma_arbit u_arbit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Stage three: command build and output register.
  rpma_cmd #(
    .ALTITUDE_SPEED (ALTITUDE_SPEED),
    .CRUISE_SPEED   (CRUISE_SPEED),
    .TURN_RATE      (TURN_RATE),
    .CENTER_SPEED   (CENTER_SPEED),
    .SEEK_SPEED     (SEEK_SPEED)
  ) u_cmd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_o.valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  assign s3_ready         = out_o.ready;
  assign out_o.speed_x    = s3_data.speed_x;
  assign out_o.speed_y    = s3_data.speed_y;
  assign out_o.speed_z    = s3_data.speed_z;
  assign out_o.yaw_rate   = s3_data.yaw_rate;
  assign out_o.rule_fired = s3_data.rule;

  // A stalled first stage keeps its beat intact.
  `RPMA_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_ready, s1_valid && $stable(s1_data), "stage one beat changed under stall")

  // Yaw commands come only from the turn and adjust rules.
  `RPMA_ASSERT_NOW(a_yaw_rule, out_o.valid && out_o.yaw_rate != '0, out_o.rule_fired == RULE_TURN_RIGHT || out_o.rule_fired == RULE_TURN_LEFT || out_o.rule_fired == RULE_ADJUST_LEFT || out_o.rule_fired == RULE_ADJUST_RIGHT, "yaw set by a rule without yaw")

  // The wall search command is a pure sideways seek.
  `RPMA_ASSERT_NOW(a_find_cmd, out_o.valid && out_o.rule_fired == RULE_FIND, out_o.speed_x == '0 && out_o.speed_y == SeekNeg && out_o.speed_z == '0 && out_o.yaw_rate == '0, "bad wall search command")

endmodule

`default_nettype wire

// ===== rtl/rpma_sense.sv =====
// ----------------------------------------------------------------------------
// rpma_sense
// First stage: range comparisons, ratio products and the diagonal push speed.
// ----------------------------------------------------------------------------
`default_nettype none

module rpma_sense import rpma_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output      logic                         ready_o,
  input  wire range_t [NUM_SENSORS-1:0]     ranges_i,
  input  wire cfg_t                         cfg_i,
  output      logic                         valid_o,
  input  wire logic                         ready_i,
  output      sense_t                       data_o
);

  logic                   valid_q;
  sense_t                 data_q;
  sense_t                 data_d;
  logic [RANGE_W-1:0]     r, fr, f, l, dn, up;
  logic [RANGE_W-1:0]     alt_mag;
  logic [RANGE_W:0]       r_plus_tol;
  logic [RANGE_W:0]       l_plus_tol;
  logic [DIAG_PROD_W-1:0] diag_prod;

  assign r  = ranges_i[SNS_RIGHT];
  assign fr = ranges_i[SNS_FRONT_RIGHT];
  assign f  = ranges_i[SNS_FRONT];
  assign l  = ranges_i[SNS_LEFT];
  assign dn = ranges_i[SNS_DOWN];
  assign up = ranges_i[SNS_UP];

  // Middle-line test is done without signs: r < l - tol is r + tol < l.
  assign r_plus_tol = {1'b0, r} + {1'b0, cfg_i.middle_tolerance};
  assign l_plus_tol = {1'b0, l} + {1'b0, cfg_i.middle_tolerance};

  // Rounded diagonal push speed.
  assign diag_prod = DIAG_PROD_W'(cfg_i.obstacle_speed) * DIAG_PROD_W'(DIAG_SCALE)
                   + DIAG_PROD_W'(DIAG_ROUND);

  assign alt_mag = (dn < up) ? (up - dn) : (dn - up);

  // Comparisons and products for the rule tests.
  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      data_d.close[i] = ranges_i[i] < cfg_i.obstacle_distance;
    end
    data_d.alt_fire       = alt_mag > cfg_i.altitude_tolerance;
    data_d.dn_lt_up       = dn < up;
    data_d.r_gt_f         = r > f;
    data_d.f_gt_r         = f > r;
    data_d.l_le_f         = l <= f;
    data_d.r_lt_l         = r < l;
    data_d.mid_out        = (r_plus_tol < {1'b0, l}) || ({1'b0, r} > l_plus_tol);
    data_d.wall           = r < cfg_i.wall_visible_distance;
    data_d.front_right    = fr;
    data_d.prod_turn      = PROD_W'(r) * PROD_W'(cfg_i.turn_ratio);
    data_d.prod_adj_left  = PROD_W'(r) * PROD_W'(cfg_i.adjust_left_ratio);
    data_d.prod_adj_right = PROD_W'(r) * PROD_W'(cfg_i.adjust_right_ratio);
    data_d.vel            = cfg_i.obstacle_speed;
    data_d.diag           = diag_prod[DIAG_PROD_W-1:DIAG_FRAC];
  end

  // Stage handshake: the register takes a new beat when empty or draining.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/rpma_arbit.sv =====
// ----------------------------------------------------------------------------
// rpma_arbit
// Second stage: ratio compares, rule priority and obstacle push coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module rpma_arbit import rpma_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output      logic   ready_o,
  input  wire sense_t data_i,
  output      logic   valid_o,
  input  wire logic   ready_i,
  output      arb_t   data_o
);

  logic              valid_q;
  arb_t              data_q;
  arb_t              data_d;
  logic [PROD_W-1:0] fr_scaled;
  logic              turn_gt;
  logic              adj_left_lt;
  logic              adj_right_gt;
  logic [NUM_SENSORS-1:0] c;

  assign c = data_i.close;

  // Front-right reading in Q4.12 against the right reading times each ratio.
  assign fr_scaled    = PROD_W'({data_i.front_right, {RATIO_FRAC{1'b0}}});
  assign turn_gt      = fr_scaled > data_i.prod_turn;
  assign adj_left_lt  = fr_scaled < data_i.prod_adj_left;
  assign adj_right_gt = fr_scaled > data_i.prod_adj_right;

  // First rule that fires wins.
  always_comb begin
    if (|c) begin
      data_d.rule = RULE_OBSTACLE;
    end else if (data_i.alt_fire) begin
      data_d.rule = RULE_ALTITUDE;
    end else if (data_i.r_gt_f && turn_gt) begin
      data_d.rule = RULE_TURN_RIGHT;
    end else if (data_i.r_gt_f) begin
      data_d.rule = RULE_TURN_LEFT;
    end else if (adj_left_lt) begin
      data_d.rule = RULE_ADJUST_LEFT;
    end else if (adj_right_gt) begin
      data_d.rule = RULE_ADJUST_RIGHT;
    end else if (data_i.l_le_f && data_i.mid_out) begin
      data_d.rule = RULE_MIDDLE;
    end else if (data_i.wall) begin
      data_d.rule = RULE_STRAIGHT;
    end else begin
      data_d.rule = RULE_FIND;
    end
  end

  // Net push count per axis, split into straight and diagonal sensors.
  always_comb begin
    data_d.dn_lt_up = data_i.dn_lt_up;
    data_d.f_gt_r   = data_i.f_gt_r;
    data_d.r_lt_l   = data_i.r_lt_l;
    data_d.x_str    = 2'(c[SNS_BACK_LOW]) - 2'(c[SNS_FRONT]);
    data_d.x_diag   = 4'(c[SNS_DOWN_BACK]) + 4'(c[SNS_UP_BACK])
                    - 4'(c[SNS_FRONT_RIGHT]) - 4'(c[SNS_FRONT_LEFT])
                    - 4'(c[SNS_DOWN_FRONT]) - 4'(c[SNS_UP_FRONT]);
    data_d.y_str    = 2'(c[SNS_RIGHT]) - 2'(c[SNS_LEFT]);
    data_d.y_diag   = 4'(c[SNS_FRONT_RIGHT]) - 4'(c[SNS_FRONT_LEFT]);
    data_d.z_str    = 2'(c[SNS_DOWN]) - 2'(c[SNS_UP]);
    data_d.z_diag   = 4'(c[SNS_DOWN_FRONT]) + 4'(c[SNS_DOWN_BACK])
                    - 4'(c[SNS_UP_BACK]) - 4'(c[SNS_UP_FRONT]);
    data_d.vel      = data_i.vel;
    data_d.diag     = data_i.diag;
  end

  // Stage handshake.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/rpma_cmd.sv =====
// ----------------------------------------------------------------------------
// rpma_cmd
// Third stage: builds the saturated velocity command for the winning rule.
// ----------------------------------------------------------------------------
`default_nettype none

module rpma_cmd import rpma_pkg::*; #(
  parameter int unsigned ALTITUDE_SPEED = ALTITUDE_SPEED_DEF,
  parameter int unsigned CRUISE_SPEED   = CRUISE_SPEED_DEF,
  parameter int unsigned TURN_RATE      = TURN_RATE_DEF,
  parameter int unsigned CENTER_SPEED   = CENTER_SPEED_DEF,
  parameter int unsigned SEEK_SPEED     = SEEK_SPEED_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output      logic ready_o,
  input  wire arb_t data_i,
  output      logic valid_o,
  input  wire logic ready_i,
  output      cmd_t data_o
);

  localparam int unsigned SUM_W = SPEED_W + 2;

  localparam logic signed [SUM_W-1:0]   SumMax   = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0]   SumMin   = SUM_W'(-32768);
  localparam logic signed [SPEED_W-1:0] AltPos   = SPEED_W'(ALTITUDE_SPEED);
  localparam logic signed [SPEED_W-1:0] AltNeg   = -AltPos;
  localparam logic signed [SPEED_W-1:0] Cruise   = SPEED_W'(CRUISE_SPEED);
  localparam logic signed [SPEED_W-1:0] TurnPos  = SPEED_W'(TURN_RATE);
  localparam logic signed [SPEED_W-1:0] TurnNeg  = -TurnPos;
  localparam logic signed [SPEED_W-1:0] CtrPos   = SPEED_W'(CENTER_SPEED);
  localparam logic signed [SPEED_W-1:0] CtrNeg   = -CtrPos;
  localparam logic signed [SPEED_W-1:0] SeekNeg  = -$signed(SPEED_W'(SEEK_SPEED));

  logic                      valid_q;
  cmd_t                      data_q;
  cmd_t                      data_d;
  logic signed [SUM_W-1:0]   x_sum, y_sum, z_sum;

  // Straight count times push speed plus diagonal count times diagonal speed.
  function automatic logic signed [SUM_W-1:0] push_sum(
    input logic [1:0]       str,
    input logic [3:0]       dia,
    input logic [VEL_W-1:0] vel,
    input logic [VEL_W-1:0] dg
  );
    return SUM_W'($signed(str)) * SUM_W'($signed({1'b0, vel}))
         + SUM_W'($signed(dia)) * SUM_W'($signed({1'b0, dg}));
  endfunction

  // Clamp to the signed 16-bit command range.
  function automatic logic signed [SPEED_W-1:0] sat_speed(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] t;
    t = v;
    if (v > SumMax) begin
      t = SumMax;
    end else if (v < SumMin) begin
      t = SumMin;
    end
    return t[SPEED_W-1:0];
  endfunction

  assign x_sum = push_sum(data_i.x_str, data_i.x_diag, data_i.vel, data_i.diag);
  assign y_sum = push_sum(data_i.y_str, data_i.y_diag, data_i.vel, data_i.diag);
  assign z_sum = push_sum(data_i.z_str, data_i.z_diag, data_i.vel, data_i.diag);

  // Command for the winning rule; fields a rule does not set stay zero.
  always_comb begin
    data_d.speed_x  = '0;
    data_d.speed_y  = '0;
    data_d.speed_z  = '0;
    data_d.yaw_rate = '0;
    data_d.rule     = data_i.rule;
    case (data_i.rule)
      RULE_OBSTACLE: begin
        data_d.speed_x = sat_speed(x_sum);
        data_d.speed_y = sat_speed(y_sum);
        data_d.speed_z = sat_speed(z_sum);
      end
      RULE_ALTITUDE: begin
        data_d.speed_z = data_i.dn_lt_up ? AltPos : AltNeg;
        data_d.speed_x = data_i.f_gt_r ? Cruise : '0;
      end
      RULE_TURN_RIGHT: begin
        data_d.yaw_rate = TurnNeg;
      end
      RULE_TURN_LEFT: begin
        data_d.yaw_rate = TurnPos;
      end
      RULE_ADJUST_LEFT: begin
        data_d.yaw_rate = TurnPos;
        data_d.speed_x  = Cruise;
      end
      RULE_ADJUST_RIGHT: begin
        data_d.yaw_rate = TurnNeg;
        data_d.speed_x  = Cruise;
      end
      RULE_MIDDLE: begin
        data_d.speed_y = data_i.r_lt_l ? CtrPos : CtrNeg;
      end
      RULE_STRAIGHT: begin
        data_d.speed_x = Cruise;
      end
      RULE_FIND: begin
        data_d.speed_y = SeekNeg;
      end
      default: begin
        data_d.speed_x = '0;
      end
    endcase
  end

  // Output register doubles as the stage register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== dv/range_priority_motion_arbiter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_priority_motion_arbiter_unit_tb
// Drives range set beats through the motion arbiter and checks every command.
// A short table of directed range sets covers each rule, the field extremes
// and the obstacle and altitude boundaries. Random range sets follow over
// several register settings, from all zeros to all ones. Each accepted beat
// is run through a local model of the rule priority unless its row fixes the
// command, and every command beat is compared with the oldest expected one.
// ----------------------------------------------------------------------------

module range_priority_motion_arbiter_unit_tb;
  import rpma_pkg::*;

  localparam int unsigned CLK_PERIOD       = 8;
  localparam int unsigned RESET_CYCLES     = 8;
  localparam int unsigned NUM_CFG_REGS     = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 112;
  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES     = 12;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned LONG_HOLD_AFTER  = 150;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned RANGE_MAX        = 65535;
  localparam int unsigned BASE_MM          = 20000;
  localparam int unsigned NEAR_MM          = 500;

  // Register settings that the run steps through.
  typedef enum int unsigned {
    PH_RESET,
    PH_ZERO,
    PH_FULL,
    PH_MODERATE,
    PH_RANDOM,
    PH_RESTORE,
    PH_COUNT
  } phase_e;

  typedef logic [NUM_SENSORS-1:0][RANGE_W-1:0] range_set_t;

  typedef struct {
    range_set_t ranges;
    bit         typed;
    cmd_t       cmd;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rpma_in_if  in_bus ();
  rpma_out_if out_bus ();

  range_priority_motion_arbiter_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Local copy of the register file and the queue of predicted commands.
  cfg_t        cfg_model;
  cmd_t        pending_commands[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count;
  int unsigned commands_seen;

  // Clamps a wide speed sum to the signed 16-bit command range.
  function automatic logic [SPEED_W-1:0] clamp_speed(input longint val);
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    return val[SPEED_W-1:0];
  endfunction

  // Computes the command that the rule priority gives for one range set.
  function automatic cmd_t predict_command(input range_set_t rs);
    longint sx, sy, sz, yaw;
    longint vel, diag, obs_dist;
    longint r, fr, f, l, dn, up;
    longint rd;
    bit     any_close;
    rule_e  rule;
    cmd_t   cmd;
    sx = 0;
    sy = 0;
    sz = 0;
    yaw = 0;
    obs_dist = longint'(cfg_model.obstacle_distance);
    vel = longint'(cfg_model.obstacle_speed);
    diag = (vel * longint'(DIAG_SCALE) + longint'(DIAG_ROUND)) >>> DIAG_FRAC;
    r  = longint'(rs[SNS_RIGHT]);
    fr = longint'(rs[SNS_FRONT_RIGHT]);
    f  = longint'(rs[SNS_FRONT]);
    l  = longint'(rs[SNS_LEFT]);
    dn = longint'(rs[SNS_DOWN]);
    up = longint'(rs[SNS_UP]);
    any_close = 1'b0;
    for (int unsigned i = 0; i < NUM_SENSORS; i++) begin
      if (longint'(rs[i]) < obs_dist) any_close = 1'b1;
    end

    if (any_close) begin
      rule = RULE_OBSTACLE;
      // Each close sensor pushes away from itself; diagonals push at 1/sqrt2.
      for (int unsigned i = 0; i < NUM_SENSORS; i++) begin
        rd = longint'(rs[i]);
        if (rd < obs_dist) begin
          case (i)
            SNS_RIGHT:       sy += vel;
            SNS_FRONT_RIGHT: begin sx -= diag; sy += diag; end
            SNS_FRONT:       sx -= vel;
            SNS_FRONT_LEFT:  begin sx -= diag; sy -= diag; end
            SNS_LEFT:        sy -= vel;
            SNS_DOWN_FRONT:  begin sx -= diag; sz += diag; end
            SNS_DOWN:        sz += vel;
            SNS_DOWN_BACK:   begin sx += diag; sz += diag; end
            SNS_BACK_LOW:    sx += vel;
            SNS_UP_BACK:     begin sx += diag; sz -= diag; end
            SNS_UP:          sz -= vel;
            SNS_UP_FRONT:    begin sx -= diag; sz -= diag; end
            default: ;
          endcase
        end
      end
    end else if (dn - up > longint'(cfg_model.altitude_tolerance) ||
                 up - dn > longint'(cfg_model.altitude_tolerance)) begin
      rule = RULE_ALTITUDE;
      sz = (dn < up) ? longint'(ALTITUDE_SPEED_DEF) : -longint'(ALTITUDE_SPEED_DEF);
      if (f > r) sx = longint'(CRUISE_SPEED_DEF);
    end else if (r > f && fr * 4096 > r * longint'(cfg_model.turn_ratio)) begin
      rule = RULE_TURN_RIGHT;
      yaw = -longint'(TURN_RATE_DEF);
    end else if (r > f) begin
      rule = RULE_TURN_LEFT;
      yaw = longint'(TURN_RATE_DEF);
    end else if (fr * 4096 < r * longint'(cfg_model.adjust_left_ratio)) begin
      rule = RULE_ADJUST_LEFT;
      yaw = longint'(TURN_RATE_DEF);
      sx = longint'(CRUISE_SPEED_DEF);
    end else if (fr * 4096 > r * longint'(cfg_model.adjust_right_ratio)) begin
      rule = RULE_ADJUST_RIGHT;
      yaw = -longint'(TURN_RATE_DEF);
      sx = longint'(CRUISE_SPEED_DEF);
    end else if (l <= f && (r < l - longint'(cfg_model.middle_tolerance) ||
                            r > l + longint'(cfg_model.middle_tolerance))) begin
      rule = RULE_MIDDLE;
      sy = (r < l) ? longint'(CENTER_SPEED_DEF) : -longint'(CENTER_SPEED_DEF);
    end else if (r < longint'(cfg_model.wall_visible_distance)) begin
      rule = RULE_STRAIGHT;
      sx = longint'(CRUISE_SPEED_DEF);
    end else begin
      rule = RULE_FIND;
      sy = -longint'(SEEK_SPEED_DEF);
    end

    cmd.speed_x  = clamp_speed(sx);
    cmd.speed_y  = clamp_speed(sy);
    cmd.speed_z  = clamp_speed(sz);
    cmd.yaw_rate = clamp_speed(yaw);
    cmd.rule     = rule;
    return cmd;
  endfunction

  // Idle gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Limits a computed reading to the range from lo up to the field maximum.
  function automatic range_t clip_range(input longint val, input longint lo);
    if (val < lo) val = lo;
    if (val > RANGE_MAX) val = RANGE_MAX;
    return val[RANGE_W-1:0];
  endfunction

  // Random reading at or above lo, at most span above it.
  function automatic range_t pick_range(input int unsigned lo, input int unsigned span);
    int unsigned hi;
    hi = (lo + span > RANGE_MAX) ? RANGE_MAX : lo + span;
    return range_t'($urandom_range(lo, hi));
  endfunction

  // Random range set. Most sets keep every sensor clear of the obstacle
  // distance and put front-right near sqrt2 times right, so that the lower
  // priority rules get exercised; the rest are raw noise or have a few
  // close sensors.
  function automatic range_set_t make_range_set();
    range_set_t  rs;
    int unsigned lo;
    int unsigned p;
    longint      w;
    longint      r;
    p  = $urandom_range(0, 99);
    lo = 32'(cfg_model.obstacle_distance);
    if (p < 20) begin
      for (int unsigned i = 0; i < NUM_SENSORS; i++) rs[i] = range_t'($urandom());
      return rs;
    end
    for (int unsigned i = 0; i < NUM_SENSORS; i++) rs[i] = pick_range(lo, 40000);
    rs[SNS_RIGHT] = pick_range(lo, 30000);
    rs[SNS_FRONT] = pick_range(lo, 30000);
    r = longint'(rs[SNS_RIGHT]);
    if ($urandom_range(0, 1) == 1) begin
      w = longint'(cfg_model.middle_tolerance) + 50;
      rs[SNS_LEFT] = clip_range(r + longint'($urandom_range(0, 2 * w)) - w, lo);
    end else begin
      rs[SNS_LEFT] = pick_range(lo, 30000);
    end
    rs[SNS_FRONT_RIGHT] = clip_range((r * longint'($urandom_range(4000, 7500))) >>> 12, lo);
    rs[SNS_DOWN] = pick_range(lo, 30000);
    if ($urandom_range(0, 9) < 7) begin
      w = longint'(cfg_model.altitude_tolerance) + longint'(cfg_model.altitude_tolerance) / 4 + 10;
      rs[SNS_UP] = clip_range(longint'(rs[SNS_DOWN]) + longint'($urandom_range(0, 2 * w)) - w,
                              lo);
    end
    if (p >= 85 && lo > 0) begin
      repeat ($urandom_range(1, 2)) begin
        rs[$urandom_range(0, NUM_SENSORS - 1)] = range_t'($urandom_range(0, lo - 1));
      end
    end
    return rs;
  endfunction

  // Reports one failed comparison; only the first few are printed.
  task automatic flag_mismatch(input string what, input cmd_t want, input cmd_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: expected x=%0d y=%0d z=%0d yaw=%0d rule=%0d, got x=%0d y=%0d z=%0d yaw=%0d rule=%0d",
               $realtime, what,
               $signed(want.speed_x), $signed(want.speed_y), $signed(want.speed_z),
               $signed(want.yaw_rate), want.rule,
               $signed(got.speed_x), $signed(got.speed_y), $signed(got.speed_z),
               $signed(got.yaw_rate), got.rule);
    end
  endtask

  // Queues one directed range set.
  task automatic add_row(input range_set_t rs, input bit typed, input cmd_t cmd);
    stim_row_t row;
    row.ranges = rs;
    row.typed  = typed;
    row.cmd    = cmd;
    directed_rows.push_back(row);
  endtask

  // Offers one range set beat after a gap and waits for it to be taken.
  task automatic send_beat(input range_set_t rs, input bit typed, input cmd_t typed_cmd,
                           input int unsigned gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid             <= 1'b1;
    in_bus.right_range       <= rs[SNS_RIGHT];
    in_bus.front_right_range <= rs[SNS_FRONT_RIGHT];
    in_bus.front_range       <= rs[SNS_FRONT];
    in_bus.front_left_range  <= rs[SNS_FRONT_LEFT];
    in_bus.left_range        <= rs[SNS_LEFT];
    in_bus.down_front_range  <= rs[SNS_DOWN_FRONT];
    in_bus.down_range        <= rs[SNS_DOWN];
    in_bus.down_back_range   <= rs[SNS_DOWN_BACK];
    in_bus.back_low_range    <= rs[SNS_BACK_LOW];
    in_bus.up_back_range     <= rs[SNS_UP_BACK];
    in_bus.up_range          <= rs[SNS_UP];
    in_bus.up_front_range    <= rs[SNS_UP_FRONT];
    // Ready seen at the falling edge holds through the next rising edge.
    @(negedge clk_i);
    while (!in_bus.ready) @(negedge clk_i);
    pending_commands.push_back(typed ? typed_cmd : predict_command(rs));
    @(posedge clk_i);
  endtask

  // Stops offering beats until every predicted command has come out.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register and mirrors the write in the local register copy.
  task automatic write_reg(input int unsigned idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[CFG_IDX_W-1:0];
    cfg_data_i <= data;
    case (idx[CFG_IDX_W-1:0])
      CFG_OBSTACLE_DISTANCE:     cfg_model.obstacle_distance     = data;
      CFG_OBSTACLE_SPEED:        cfg_model.obstacle_speed        = data[VEL_W-1:0];
      CFG_ALTITUDE_TOLERANCE:    cfg_model.altitude_tolerance    = data;
      CFG_MIDDLE_TOLERANCE:      cfg_model.middle_tolerance      = data;
      CFG_WALL_VISIBLE_DISTANCE: cfg_model.wall_visible_distance = data;
      CFG_TURN_RATIO:            cfg_model.turn_ratio            = data;
      CFG_ADJUST_LEFT_RATIO:     cfg_model.adjust_left_ratio     = data;
      CFG_ADJUST_RIGHT_RATIO:    cfg_model.adjust_right_ratio    = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Command beat checker: each beat is taken at the next rising edge.
  always @(negedge clk_i) begin
    cmd_t got_cmd;
    cmd_t want_cmd;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got_cmd.speed_x  = out_bus.speed_x;
      got_cmd.speed_y  = out_bus.speed_y;
      got_cmd.speed_z  = out_bus.speed_z;
      got_cmd.yaw_rate = out_bus.yaw_rate;
      got_cmd.rule     = rule_e'(out_bus.rule_fired);
      commands_seen++;
      if (pending_commands.size() == 0) begin
        flag_mismatch("unexpected command beat", '0, got_cmd);
      end else begin
        want_cmd = pending_commands.pop_front();
        if (got_cmd !== want_cmd) flag_mismatch("command mismatch", want_cmd, got_cmd);
      end
    end
  end

  // Receiver: random hold-offs, runs of steady ready, and one long hold-off
  // that lets the pipeline fill and stall its input.
  initial begin
    int unsigned stall_left;
    int unsigned steady_left;
    bit          long_hold_done;
    stall_left     = 0;
    steady_left    = 0;
    long_hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!long_hold_done && commands_seen >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        out_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        steady_left = $urandom_range(20, 60);
        out_bus.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_bus.ready <= 1'b0;
        end else begin
          out_bus.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("range_priority_motion_arbiter_unit: mismatch");
    $finish;
  end

  // Stimulus: reset, directed table, then random beats under each setting.
  initial begin
    range_set_t                  rs;
    cmd_t                        cmd;
    phase_e                      phase;
    logic [CFG_DATA_W-1:0]       cfg_words [NUM_CFG_REGS];
    int unsigned                 tx_steady_left;
    int unsigned                 gap;
    mismatch_count   = 0;
    commands_seen    = 0;
    tx_steady_left   = 0;
    cfg_model.obstacle_distance     = OBSTACLE_DISTANCE_RST;
    cfg_model.obstacle_speed        = OBSTACLE_SPEED_RST;
    cfg_model.altitude_tolerance    = ALTITUDE_TOLERANCE_RST;
    cfg_model.middle_tolerance      = MIDDLE_TOLERANCE_RST;
    cfg_model.wall_visible_distance = WALL_VISIBLE_DISTANCE_RST;
    cfg_model.turn_ratio            = TURN_RATIO_RST;
    cfg_model.adjust_left_ratio     = ADJUST_LEFT_RATIO_RST;
    cfg_model.adjust_right_ratio    = ADJUST_RIGHT_RATIO_RST;

    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    in_bus.valid             <= 1'b0;
    in_bus.right_range       <= '0;
    in_bus.front_right_range <= '0;
    in_bus.front_range       <= '0;
    in_bus.front_left_range  <= '0;
    in_bus.left_range        <= '0;
    in_bus.down_front_range  <= '0;
    in_bus.down_range        <= '0;
    in_bus.down_back_range   <= '0;
    in_bus.back_low_range    <= '0;
    in_bus.up_back_range     <= '0;
    in_bus.up_range          <= '0;
    in_bus.up_front_range    <= '0;

    // Directed table, all under the reset register values.
    // Every sensor at zero: the straight pushes cancel and y and z cancel, but
    // four forward diagonals against two backward ones leave two diagonal
    // pushes of 354 toward the back.
    add_row('0, 1'b1, '{speed_x: -16'sd708, speed_y: '0, speed_z: '0, yaw_rate: '0,
                        rule: RULE_OBSTACLE});
    // Every sensor at full scale: front-right is not far enough out, so adjust left.
    add_row('1, 1'b1, '{speed_x: 16'd500, speed_y: '0, speed_z: '0, yaw_rate: 16'd500,
                        rule: RULE_ADJUST_LEFT});
    // One close sensor at a time shows each push direction.
    for (int unsigned s = 0; s < NUM_SENSORS; s++) begin
      rs = {NUM_SENSORS{range_t'(BASE_MM)}};
      rs[s] = range_t'(NEAR_MM);
      add_row(rs, 1'b0, '0);
    end
    // A reading equal to the obstacle distance does not count as close.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_FRONT] = OBSTACLE_DISTANCE_RST;
    add_row(rs, 1'b0, '0);
    // Too high: climb down at the altitude speed, no forward speed.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_DOWN] = 16'd5000;
    rs[SNS_UP]   = 16'd2000;
    add_row(rs, 1'b1, '{speed_x: '0, speed_y: '0, speed_z: -16'sd300, yaw_rate: '0,
                        rule: RULE_ALTITUDE});
    // Too low with open space ahead: climb and cruise.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_DOWN]  = 16'd2000;
    rs[SNS_UP]    = 16'd5000;
    rs[SNS_FRONT] = 16'd30000;
    add_row(rs, 1'b0, '0);
    // Altitude difference exactly at the tolerance does not fire.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_DOWN] = range_t'(BASE_MM) + ALTITUDE_TOLERANCE_RST;
    add_row(rs, 1'b0, '0);
    // Turn right, then turn left.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_RIGHT]       = 16'd30000;
    rs[SNS_FRONT_RIGHT] = 16'd65535;
    add_row(rs, 1'b0, '0);
    rs[SNS_FRONT_RIGHT] = range_t'(BASE_MM);
    add_row(rs, 1'b0, '0);
    // Adjust right.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_FRONT_RIGHT] = 16'd40000;
    add_row(rs, 1'b0, '0);
    // Off the middle line toward the right, then toward the left.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_RIGHT]       = 16'd10000;
    rs[SNS_FRONT_RIGHT] = 16'd14142;
    rs[SNS_LEFT]        = 16'd12000;
    add_row(rs, 1'b0, '0);
    rs[SNS_LEFT] = 16'd5000;
    add_row(rs, 1'b0, '0);
    // Wall in sight and centered: go straight.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_RIGHT]       = 16'd5000;
    rs[SNS_LEFT]        = 16'd5000;
    rs[SNS_FRONT_RIGHT] = 16'd7071;
    add_row(rs, 1'b0, '0);
    // No wall in sight: find one.
    rs = {NUM_SENSORS{range_t'(BASE_MM)}};
    rs[SNS_FRONT]       = 16'd30000;
    rs[SNS_FRONT_RIGHT] = 16'd28284;
    add_row(rs, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned p = 0; p < PH_COUNT; p++) begin
      phase = phase_e'(p);
      if (phase != PH_RESET) begin
        wait_idle();
        case (phase)
          PH_ZERO: begin
            for (int unsigned i = 0; i < NUM_CFG_REGS; i++) cfg_words[i] = '0;
          end
          PH_FULL: begin
            // Obstacle speed bits above its width must be dropped.
            for (int unsigned i = 0; i < NUM_CFG_REGS; i++) cfg_words[i] = '1;
          end
          PH_MODERATE: begin
            cfg_words[CFG_OBSTACLE_DISTANCE]     = CFG_DATA_W'($urandom_range(0, 3000));
            cfg_words[CFG_OBSTACLE_SPEED]        = CFG_DATA_W'($urandom());
            cfg_words[CFG_ALTITUDE_TOLERANCE]    = CFG_DATA_W'($urandom_range(0, 3000));
            cfg_words[CFG_MIDDLE_TOLERANCE]      = CFG_DATA_W'($urandom_range(0, 3000));
            cfg_words[CFG_WALL_VISIBLE_DISTANCE] = CFG_DATA_W'($urandom_range(0, 50000));
            cfg_words[CFG_TURN_RATIO]            = CFG_DATA_W'($urandom_range(3000, 9000));
            cfg_words[CFG_ADJUST_LEFT_RATIO]     = CFG_DATA_W'($urandom_range(3000, 7000));
            cfg_words[CFG_ADJUST_RIGHT_RATIO]    = CFG_DATA_W'($urandom_range(5000, 9000));
          end
          PH_RANDOM: begin
            for (int unsigned i = 0; i < NUM_CFG_REGS; i++) begin
              cfg_words[i] = CFG_DATA_W'($urandom());
            end
          end
          default: begin
            cfg_words[CFG_OBSTACLE_DISTANCE]     = OBSTACLE_DISTANCE_RST;
            cfg_words[CFG_OBSTACLE_SPEED]        = {4'hF, OBSTACLE_SPEED_RST};
            cfg_words[CFG_ALTITUDE_TOLERANCE]    = ALTITUDE_TOLERANCE_RST;
            cfg_words[CFG_MIDDLE_TOLERANCE]      = MIDDLE_TOLERANCE_RST;
            cfg_words[CFG_WALL_VISIBLE_DISTANCE] = WALL_VISIBLE_DISTANCE_RST;
            cfg_words[CFG_TURN_RATIO]            = TURN_RATIO_RST;
            cfg_words[CFG_ADJUST_LEFT_RATIO]     = ADJUST_LEFT_RATIO_RST;
            cfg_words[CFG_ADJUST_RIGHT_RATIO]    = ADJUST_RIGHT_RATIO_RST;
          end
        endcase
        for (int unsigned i = 0; i < NUM_CFG_REGS; i++) write_reg(i, cfg_words[i]);
        // A write past the last register must leave every register alone.
        write_reg($urandom_range(NUM_CFG_REGS, (1 << CFG_IDX_W) - 1),
                  CFG_DATA_W'($urandom()));
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        foreach (directed_rows[i]) begin
          send_beat(directed_rows[i].ranges, directed_rows[i].typed, directed_rows[i].cmd,
                    pick_gap());
        end
      end

      // Random beats, with runs of back-to-back offers mixed in.
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (tx_steady_left == 0 && $urandom_range(0, 99) < 3) begin
          tx_steady_left = $urandom_range(20, 60);
        end
        if (tx_steady_left > 0) begin
          tx_steady_left--;
          gap = 0;
        end else begin
          gap = pick_gap();
        end
        cmd = '0;
        send_beat(make_range_set(), 1'b0, cmd, gap);
      end
    end

    // Drain, then keep watching for any stray command beat before the verdict.
    in_bus.valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_commands.size() == 0) begin
      $display("range_priority_motion_arbiter_unit: match");
    end else begin
      $display("range_priority_motion_arbiter_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rpma_pkg.sv
rtl/rpma_if.sv
rtl/rpma_sense.sv
rtl/rpma_arbit.sv
rtl/rpma_cmd.sv
rtl/range_priority_motion_arbiter_unit.sv
dv/range_priority_motion_arbiter_unit_tb.sv
